/* hdl/lzwc_pkg.sv */
// Package with the transaction types and constants of the LZW compressor.
package lzwc_pkg;

  localparam int OUT_W   = 12;
  localparam int BYTE_W  = 8;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] code;
    logic             last_code;
  } out_item_t;

endpackage

/* hdl/lzwc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/lzwc_front.sv */
// Input stage: holds accepted transactions in a two-entry queue.
module lzwc_front
  import lzwc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output in_item_t q_item
);

  in_item_t   buf_r [2];
  logic       rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

/* hdl/lzwc_back.sv */
// Dictionary engine: hashing, probing, insertion, clearing and code output.
module lzwc_back
  import lzwc_pkg::*;
#(
  parameter int CODE_BITS  = 12,
  parameter int HASH_SLOTS = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  in_item_t  q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(HASH_SLOTS);
  localparam int EW = CODE_BITS + 1;
  // Slot word: epoch, prefix, byte, code.
  localparam int SW = EW + CODE_BITS + BYTE_W + CODE_BITS;
  localparam logic [CODE_BITS:0] FIRST_FREE = (CODE_BITS+1)'(256);
  localparam logic [CODE_BITS:0] CODE_LIMIT = (CODE_BITS+1)'(1) << CODE_BITS;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_HASH  = 4'd2;
  localparam logic [3:0] ST_MIX   = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_CMP   = 4'd5;
  localparam logic [3:0] ST_EMIT  = 4'd6;
  localparam logic [3:0] ST_LAST  = 4'd7;

  logic [3:0]           st_r, st_nxt;
  logic [CODE_BITS-1:0] prefix_r, prefix_nxt;
  logic                 pvalid_r, pvalid_nxt;
  logic [CODE_BITS:0]   nfc_r, nfc_nxt;
  logic [EW-1:0]        epoch_r, epoch_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW:0]          probes_r, probes_nxt;
  logic [31:0]          key_r, key_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 last_r, last_nxt;
  logic [3:0]           resume_r, resume_nxt;
  out_item_t            obuf_r, obuf_nxt;
  logic                 ovalid_r, ovalid_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [SW-1:0] wr_data, rd_data;
  logic [EW-1:0]        s_epoch;
  logic [CODE_BITS-1:0] s_prefix, s_code;
  logic [7:0]           s_byte;
  logic [31:0]          mixed;
  logic                 out_free;

  lzwc_ram #(.WIDTH(SW), .DEPTH(HASH_SLOTS)) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign {s_epoch, s_prefix, s_byte, s_code} = rd_data;
  assign mixed     = key_r ^ (key_r >> 15);
  assign out_valid = ovalid_r;
  assign out_data  = obuf_r;
  assign out_free  = !ovalid_r || out_ready;
  assign rd_addr   = pos_r;

  // Sequencer for one byte: hash, probe, then insert or follow.
  always_comb begin
    st_nxt = st_r; prefix_nxt = prefix_r; pvalid_nxt = pvalid_r;
    nfc_nxt = nfc_r; epoch_nxt = epoch_r; clr_nxt = clr_r;
    pos_nxt = pos_r; probes_nxt = probes_r; key_nxt = key_r;
    byte_nxt = byte_r; last_nxt = last_r; resume_nxt = resume_r;
    obuf_nxt = obuf_r; ovalid_nxt = ovalid_r && !out_ready;
    q_pop = 1'b0; wr_en = 1'b0; wr_addr = clr_r;
    wr_data = '0;
    case (st_r)
      // Sweep after reset and on epoch wrap so every slot holds an epoch that never matches.
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = {{EW{1'b1}}, {(SW-EW){1'b0}}};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(HASH_SLOTS - 1)) begin
          st_nxt = resume_r;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          byte_nxt = q_item.data_byte;
          last_nxt = q_item.is_last;
          // A full dictionary is emptied by moving to a new epoch.
          if (nfc_r >= CODE_LIMIT) begin
            nfc_nxt   = FIRST_FREE;
            epoch_nxt = epoch_r + 1'b1;
          end
          if (!pvalid_r) begin
            prefix_nxt = CODE_BITS'(q_item.data_byte);
            pvalid_nxt = 1'b1;
            st_nxt     = q_item.is_last ? ST_LAST : ST_IDLE;
          end else begin
            key_nxt = 32'({prefix_r, q_item.data_byte}) * HASH_MULT;
            st_nxt  = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        pos_nxt    = AW'(mixed % HASH_SLOTS);
        probes_nxt = '0;
        st_nxt     = ST_MIX;
      end
      // Wait for the registered read of the current slot.
      ST_MIX: st_nxt = ST_CMP;
      ST_RD:  st_nxt = ST_CMP;
      ST_CMP: begin
        if (s_epoch != epoch_r) begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = {epoch_r, prefix_r, byte_r, nfc_r[CODE_BITS-1:0]};
          st_nxt  = ST_EMIT;
        end else if (s_prefix == prefix_r && s_byte == byte_r) begin
          prefix_nxt = s_code;
          st_nxt     = last_r ? ST_LAST : ST_IDLE;
        end else if (probes_r == (AW+1)'(HASH_SLOTS - 1)) begin
          st_nxt = ST_EMIT;
        end else begin
          probes_nxt = probes_r + 1'b1;
          pos_nxt    = pos_r + 1'b1;
          st_nxt     = ST_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          obuf_nxt.code      = OUT_W'(prefix_r);
          obuf_nxt.last_code = 1'b0;
          ovalid_nxt = 1'b1;
          nfc_nxt    = nfc_r + 1'b1;
          prefix_nxt = CODE_BITS'(byte_r);
          st_nxt     = last_r ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          obuf_nxt.code      = OUT_W'(prefix_r);
          obuf_nxt.last_code = 1'b1;
          ovalid_nxt = 1'b1;
          nfc_nxt    = FIRST_FREE;
          epoch_nxt  = epoch_r + 1'b1;
          prefix_nxt = '0;
          pvalid_nxt = 1'b0;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    // Epoch wrap would revive stale slots: sweep again, then carry on
    // with the step that was about to start.
    if (epoch_nxt == {EW{1'b1}} && st_r != ST_CLEAR) begin
      epoch_nxt  = '0;
      clr_nxt    = '0;
      resume_nxt = st_nxt;
      st_nxt     = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLEAR;
      prefix_r <= '0;
      pvalid_r <= 1'b0;
      nfc_r    <= FIRST_FREE;
      epoch_r  <= '0;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      resume_r <= ST_IDLE;
    end else begin
      st_r     <= st_nxt;
      prefix_r <= prefix_nxt;
      pvalid_r <= pvalid_nxt;
      nfc_r    <= nfc_nxt;
      epoch_r  <= epoch_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      resume_r <= resume_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    probes_r <= probes_nxt;
    key_r    <= key_nxt;
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    obuf_r   <= obuf_nxt;
  end

endmodule

/* hdl/lzw_compressor_core.sv */
// A byte passes from the queue through hashing, a slot read and a compare; a miss inserts the
// string and emits the prefix code, a hit extends the prefix, and a mismatch probes the next slot.
// The first byte of a stream only becomes the prefix; a last byte also emits its final code.
// The engine takes one byte at a time; the two-entry queue holds further bytes until it is done.
// After reset a sweep marks every slot empty; bytes queue meanwhile.
// The sweep reruns on epoch wrap. Reset is synchronous, active low; queue and output emptied.
module lzw_compressor_core
  import lzwc_pkg::*;
#(
  parameter int CODE_BITS  = 12,
  parameter int HASH_SLOTS = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     q_valid, q_pop;
  in_item_t q_item;

  // Input queue.
  lzwc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_pop, .q_item
  );

  // Dictionary engine.
  lzwc_back #(.CODE_BITS(CODE_BITS), .HASH_SLOTS(HASH_SLOTS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .out_valid, .out_ready, .out_data
  );

endmodule

/* hdl/lzwc_checker.sv */
// Port-level checker for the LZW compressor, bound to the top level.
module lzwc_checker
  import lzwc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input is accepted in the cycle after reset, since the queue is cleared.
  a_ready_rst: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("queue not empty after reset");

endmodule

bind lzw_compressor_core lzwc_checker u_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data
);
